// File: hdl/hpf_pkg.sv
`default_nettype none

package hpf_pkg;

    // Histogram geometry
    localparam int BIN_BITS   = 8;
    localparam int COUNT_BITS = 31;
    localparam int NBINS      = 1 << BIN_BITS;

    // Query fields and exact arithmetic widths
    localparam int PCT_BITS     = 23;
    localparam int PCT_SHIFT    = 16;
    localparam int SUM_BITS     = COUNT_BITS + BIN_BITS;
    localparam int H100_BITS    = COUNT_BITS + 7;
    localparam int T100_BITS    = SUM_BITS + 7;
    localparam int NPTS_LO_BITS = (SUM_BITS + 1) / 2;
    localparam int NPTS_HI_BITS = SUM_BITS - NPTS_LO_BITS;
    localparam int PLO_BITS     = PCT_BITS + NPTS_LO_BITS;
    localparam int PHI_BITS     = PCT_BITS + NPTS_HI_BITS;
    localparam int PROD_BITS    = PCT_BITS + SUM_BITS;
    localparam int CMP_BITS     = PROD_BITS + 2;

    // One hundred percent in units of 1/65536 percent
    localparam logic [PCT_BITS-1:0] PCT_FULL = PCT_BITS'(100 << PCT_SHIFT);

    // Top address bit, flipped to store two's complement codes
    localparam logic [BIN_BITS-1:0] HALF_ADDR = BIN_BITS'(1 << (BIN_BITS - 1));

    // Stream payload widths
    localparam int IN_TDATA_BITS  = 80;
    localparam int OUT_TDATA_BITS = 8;

    // Input tuser kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Histogram memory request groups
    typedef struct packed {
        logic                  en;
        logic [BIN_BITS-1:0]   addr;
        logic [COUNT_BITS-1:0] data;
    } hpf_wr_req_t;

    typedef struct packed {
        logic                en;
        logic [BIN_BITS-1:0] addr;
    } hpf_rd_req_t;

    // Map a bin code to its memory address and back (the mapping is its own inverse)
    function automatic logic [BIN_BITS-1:0] hpf_code_to_addr(
        input logic [BIN_BITS-1:0] code,
        input logic                sgn
    );
        return code ^ (sgn ? HALF_ADDR : '0);
    endfunction

    // Multiply a count by 100 with shifts and adds
    function automatic logic [H100_BITS-1:0] hpf_times100(input logic [COUNT_BITS-1:0] h);
        logic [H100_BITS-1:0] hx;
        hx = H100_BITS'(h);
        return (hx << 6) + (hx << 5) + (hx << 2);
    endfunction

endpackage

`default_nettype wire

// File: hdl/hpf_hist_ram.sv
`default_nettype none

module hpf_hist_ram
    import hpf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hpf_wr_req_t           wr_req,
    input  wire hpf_rd_req_t           rd_req,
    output logic [COUNT_BITS-1:0]      rd_data
);

    logic [COUNT_BITS-1:0] mem [NBINS];
    logic [NBINS-1:0]      valid_reg;
    logic [COUNT_BITS-1:0] data_reg;
    logic                  data_valid_reg;

    // Count storage, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.en)
        begin
            data_reg <= mem[rd_req.addr];
        end
    end

    // Per-bin written flags; an unwritten bin reads as an empty bin after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            data_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_req.en)
            begin
                valid_reg[wr_req.addr] <= 1'b1;
            end
            if (rd_req.en)
            begin
                data_valid_reg <= valid_reg[rd_req.addr];
            end
        end
    end

    assign rd_data = data_valid_reg ? data_reg : '0;

endmodule

`default_nettype wire

// File: hdl/histogram_percentile_finder_unit.sv
// Histogram percentile finder.
// Input stream (s_axis_*): tuser selects the transaction kind. A write transaction
// stores bin_count into bin bin_index; it gives no result. A query
// transaction asks for the bin at which percent (Q7.16) of the counts in the inclusive
// range low_bin..high_bin is reached, and gives one result on the output stream
// (m_axis_*): tuser is the status (1 on a bad percent, a reversed or an empty range),
// tdata the bin code found (zero on error).
// The cfg_we / cfg_wdata port sets the signed-bin mode; write it only while idle.
// A query makes two passes over its range through the one read port of the histogram
// memory, one bin per cycle: a summing pass, then a scan that stops at the answer.
// The input is refused while a query runs. A finished result sits in the output
// register; a further query waits in its last step while the receiver stalls, and no
// write transactions are taken meanwhile.
// Reset marks every bin empty at once and clears the signed-bin mode.
`default_nettype none

module histogram_percentile_finder_unit
    import hpf_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Configuration: signed_bins
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_wdata,
    // Input stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] bin_index, [38:8] bin_count, [61:39] percent, [69:62] low_bin,
    // [77:70] high_bin, [79:78] zero
    input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // [0] action
    input  wire logic [0:0]                s_axis_tuser,
    // Output stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // [7:0] result_bin
    output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata,
    // [0] status
    output logic [0:0]                     m_axis_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ADD,
        ST_SCAN,
        ST_PICK,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic                    signed_bins_reg;

    logic [PCT_BITS-1:0]     pct_reg, pct_next;
    logic [BIN_BITS-1:0]     lo_reg, lo_next;
    logic [BIN_BITS-1:0]     hi_reg, hi_next;
    logic                    err_reg, err_next;

    logic [BIN_BITS-1:0]     addr_reg, addr_next;
    logic                    issued_reg, issued_next;
    logic                    p1_valid_reg, p1_valid_next;
    logic                    p1_last_reg, p1_last_next;
    logic [BIN_BITS-1:0]     p1_addr_reg, p1_addr_next;
    logic                    s2_valid_reg, s2_valid_next;
    logic                    s2_last_reg, s2_last_next;
    logic                    s2_nz_reg, s2_nz_next;
    logic [BIN_BITS-1:0]     s2_addr_reg, s2_addr_next;
    logic [H100_BITS-1:0]    s2_h100_reg, s2_h100_next;

    logic [SUM_BITS-1:0]     npts_reg, npts_next;
    logic [PLO_BITS-1:0]     plo_reg, plo_next;
    logic [PHI_BITS-1:0]     phi_reg, phi_next;
    logic [PROD_BITS-1:0]    p_reg, p_next;

    logic [T100_BITS-1:0]    tot100_reg, tot100_next;
    logic [T100_BITS-1:0]    lasttot100_reg, lasttot100_next;
    logic [BIN_BITS-1:0]     last_reg, last_next;
    logic                    seen_reg, seen_next;
    logic [T100_BITS-1:0]    tnew100_reg, tnew100_next;
    logic [T100_BITS-1:0]    ltot100_reg, ltot100_next;
    logic [BIN_BITS-1:0]     cand_reg, cand_next;
    logic [BIN_BITS-1:0]     pick_last_reg, pick_last_next;
    logic [BIN_BITS-1:0]     res_reg, res_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_status_reg, out_status_next;
    logic [BIN_BITS-1:0]     out_bin_reg, out_bin_next;

    hpf_wr_req_t             wr_req;
    hpf_rd_req_t             rd_req;
    logic [COUNT_BITS-1:0]   rd_data;

    logic                    in_fire;
    logic [BIN_BITS-1:0]     in_bin_index;
    logic [COUNT_BITS-1:0]   in_bin_count;
    logic [PCT_BITS-1:0]     in_percent;
    logic [BIN_BITS-1:0]     in_lo_addr;
    logic [BIN_BITS-1:0]     in_hi_addr;

    logic [SUM_BITS-1:0]     npts_sum;
    logic [T100_BITS-1:0]    t100;
    logic                    reach;
    logic [T100_BITS:0]      near_sum;
    logic                    near;

    // Input field unpacking
    assign in_fire      = s_axis_tvalid && s_axis_tready;
    assign in_bin_index = s_axis_tdata[7:0];
    assign in_bin_count = s_axis_tdata[38:8];
    assign in_percent   = s_axis_tdata[61:39];
    assign in_lo_addr   = hpf_code_to_addr(s_axis_tdata[69:62], signed_bins_reg);
    assign in_hi_addr   = hpf_code_to_addr(s_axis_tdata[77:70], signed_bins_reg);

    // Write transactions go straight into the memory; reads only happen during a query
    assign wr_req.en   = in_fire && (s_axis_tuser[0] == ACT_WRITE);
    assign wr_req.addr = hpf_code_to_addr(in_bin_index, signed_bins_reg);
    assign wr_req.data = in_bin_count;

    hpf_hist_ram u_hist_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_req  (wr_req),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    // Datapath terms for the summing pass, the scan and the final choice
    assign npts_sum = npts_reg + SUM_BITS'(rd_data);
    assign t100     = tot100_reg + T100_BITS'(s2_h100_reg);
    assign reach    = CMP_BITS'({t100, PCT_SHIFT'(0)}) >= CMP_BITS'(p_reg);
    assign near_sum = (T100_BITS + 1)'(tnew100_reg) + (T100_BITS + 1)'(ltot100_reg);
    assign near     = CMP_BITS'({p_reg, 1'b0}) < CMP_BITS'({near_sum, PCT_SHIFT'(0)});

    assign s_axis_tready = (state_reg == ST_IDLE);

    // Next-state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        pct_next        = pct_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        err_next        = err_reg;
        addr_next       = addr_reg;
        issued_next     = issued_reg;
        p1_valid_next   = 1'b0;
        p1_last_next    = p1_last_reg;
        p1_addr_next    = p1_addr_reg;
        s2_valid_next   = 1'b0;
        s2_last_next    = p1_last_reg;
        s2_nz_next      = (rd_data != '0);
        s2_addr_next    = p1_addr_reg;
        s2_h100_next    = hpf_times100(rd_data);
        npts_next       = npts_reg;
        plo_next        = plo_reg;
        phi_next        = phi_reg;
        p_next          = p_reg;
        tot100_next     = tot100_reg;
        lasttot100_next = lasttot100_reg;
        last_next       = last_reg;
        seen_next       = seen_reg;
        tnew100_next    = tnew100_reg;
        ltot100_next    = ltot100_reg;
        cand_next       = cand_reg;
        pick_last_next  = pick_last_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_bin_next    = out_bin_reg;
        rd_req.en       = 1'b0;
        rd_req.addr     = addr_reg;

        // Read issue, one bin per cycle from the low end to the high end of the range
        if ((state_reg == ST_SUM || state_reg == ST_SCAN) && !issued_reg)
        begin
            rd_req.en     = 1'b1;
            p1_valid_next = 1'b1;
            p1_last_next  = (addr_reg == hi_reg);
            p1_addr_next  = addr_reg;
            if (addr_reg == hi_reg)
            begin
                issued_next = 1'b1;
            end
            else
            begin
                addr_next = addr_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (s_axis_tuser[0] == ACT_QUERY))
                begin
                    pct_next    = in_percent;
                    lo_next     = in_lo_addr;
                    hi_next     = in_hi_addr;
                    addr_next   = in_lo_addr;
                    issued_next = 1'b0;
                    npts_next   = '0;
                    if (in_percent > PCT_FULL || in_hi_addr < in_lo_addr)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = ST_SUM;
                    end
                end
            end

            ST_SUM:
            begin
                if (p1_valid_reg)
                begin
                    npts_next = npts_sum;
                    if (p1_last_reg)
                    begin
                        if (npts_sum == '0)
                        begin
                            err_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_MUL_LO;
                        end
                    end
                end
            end

            // pct * npts in two partial products and a final add
            ST_MUL_LO:
            begin
                plo_next   = PLO_BITS'(pct_reg) * PLO_BITS'(npts_reg[NPTS_LO_BITS-1:0]);
                state_next = ST_MUL_HI;
            end

            ST_MUL_HI:
            begin
                phi_next   = PHI_BITS'(pct_reg) * PHI_BITS'(npts_reg[SUM_BITS-1:NPTS_LO_BITS]);
                state_next = ST_MUL_ADD;
            end

            ST_MUL_ADD:
            begin
                p_next      = PROD_BITS'(plo_reg) + (PROD_BITS'(phi_reg) << NPTS_LO_BITS);
                addr_next   = lo_reg;
                issued_next = 1'b0;
                tot100_next = '0;
                seen_next   = 1'b0;
                state_next  = ST_SCAN;
            end

            // Running sum over nonzero bins until the target share is reached or the range ends
            ST_SCAN:
            begin
                s2_valid_next = p1_valid_reg;
                if (s2_valid_reg)
                begin
                    if ((s2_nz_reg && reach) || s2_last_reg)
                    begin
                        tnew100_next   = t100;
                        ltot100_next   = seen_reg ? lasttot100_reg : t100;
                        cand_next      = s2_addr_reg;
                        pick_last_next = seen_reg ? last_reg : s2_addr_reg;
                        state_next     = ST_PICK;
                    end
                    else if (s2_nz_reg)
                    begin
                        tot100_next     = t100;
                        lasttot100_next = t100;
                        last_next       = s2_addr_reg;
                        seen_next       = 1'b1;
                    end
                end
            end

            // Take the previous nonzero bin when it lies strictly nearer the target
            ST_PICK:
            begin
                res_next   = hpf_code_to_addr(near ? pick_last_reg : cand_reg,
                                              signed_bins_reg);
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = err_reg ? STATUS_ERR : STATUS_OK;
                    out_bin_next    = err_reg ? '0 : res_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Drop reads still in flight when a pass ends
        if (state_next != state_reg)
        begin
            p1_valid_next = 1'b0;
            s2_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            signed_bins_reg <= 1'b0;
            pct_reg         <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            err_reg         <= 1'b0;
            addr_reg        <= '0;
            issued_reg      <= 1'b0;
            p1_valid_reg    <= 1'b0;
            p1_last_reg     <= 1'b0;
            p1_addr_reg     <= '0;
            s2_valid_reg    <= 1'b0;
            s2_last_reg     <= 1'b0;
            s2_nz_reg       <= 1'b0;
            s2_addr_reg     <= '0;
            s2_h100_reg     <= '0;
            npts_reg        <= '0;
            plo_reg         <= '0;
            phi_reg         <= '0;
            p_reg           <= '0;
            tot100_reg      <= '0;
            lasttot100_reg  <= '0;
            last_reg        <= '0;
            seen_reg        <= 1'b0;
            tnew100_reg     <= '0;
            ltot100_reg     <= '0;
            cand_reg        <= '0;
            pick_last_reg   <= '0;
            res_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= STATUS_OK;
            out_bin_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
            begin
                signed_bins_reg <= cfg_wdata;
            end
            pct_reg         <= pct_next;
            lo_reg          <= lo_next;
            hi_reg          <= hi_next;
            err_reg         <= err_next;
            addr_reg        <= addr_next;
            issued_reg      <= issued_next;
            p1_valid_reg    <= p1_valid_next;
            p1_last_reg     <= p1_last_next;
            p1_addr_reg     <= p1_addr_next;
            s2_valid_reg    <= s2_valid_next;
            s2_last_reg     <= s2_last_next;
            s2_nz_reg       <= s2_nz_next;
            s2_addr_reg     <= s2_addr_next;
            s2_h100_reg     <= s2_h100_next;
            npts_reg        <= npts_next;
            plo_reg         <= plo_next;
            phi_reg         <= phi_next;
            p_reg           <= p_next;
            tot100_reg      <= tot100_next;
            lasttot100_reg  <= lasttot100_next;
            last_reg        <= last_next;
            seen_reg        <= seen_next;
            tnew100_reg     <= tnew100_next;
            ltot100_reg     <= ltot100_next;
            cand_reg        <= cand_next;
            pick_last_reg   <= pick_last_next;
            res_reg         <= res_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_bin_reg     <= out_bin_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_bin_reg;
    assign m_axis_tuser[0] = out_status_reg;

    // A query transaction always leaves the idle state
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_axis_tuser[0] == ACT_QUERY)) |=> (state_reg != ST_IDLE))
        else $error("query transaction did not start a search");

    // A successful answer needs a nonzero range sum
    a_ok_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !err_reg) |-> (npts_reg != '0))
        else $error("success reported on an empty range");

    // The chosen bins lie inside the range and the fallback is not above the hit
    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) |-> (cand_reg >= lo_reg && cand_reg <= hi_reg &&
                                    pick_last_reg >= lo_reg && pick_last_reg <= cand_reg))
        else $error("scan stopped outside the query range");

    // Memory reads and write transactions never share a cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rd_req.en |-> !wr_req.en)
        else $error("histogram read overlaps a write");

endmodule

`default_nettype wire

// File: verif/hpf_checker.sv
`timescale 1ns / 100ps

module hpf_checker
    import hpf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_wdata,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    // [7:0] bin_index, [38:8] bin_count, [61:39] percent, [69:62] low_bin,
    // [77:70] high_bin, [79:78] zero
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // [0] action
    input  logic [0:0]                s_axis_tuser,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [7:0] result_bin
    input  logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    // [0] status
    input  logic [0:0]                m_axis_tuser,
    output int                        mismatch_count,
    output int                        open_results
);

    // Bit offsets of the fields inside the input tdata.
    localparam int IDX_LSB = 0;
    localparam int CNT_LSB = IDX_LSB + BIN_BITS;
    localparam int PCT_LSB = CNT_LSB + COUNT_BITS;
    localparam int LO_LSB  = PCT_LSB + PCT_BITS;
    localparam int HI_LSB  = LO_LSB + BIN_BITS;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                status;
        logic [BIN_BITS-1:0] bin;
    } answer_t;

    // Shadow copy of the histogram memory and the signed-bin mode.
    logic [COUNT_BITS-1:0] bin_counts [NBINS];
    logic                  signed_mode;
    answer_t               answers_due [$];
    int                    failures;

    // Exact percentile search over the shadow histogram. All comparisons are done
    // as cross products in wide vectors, so no rounding enters the answer.
    function automatic answer_t find_percentile(
        input logic [PCT_BITS-1:0] pct,
        input logic [BIN_BITS-1:0] low_code,
        input logic [BIN_BITS-1:0] high_code
    );
        answer_t             ans;
        logic [BIN_BITS-1:0] flip;
        int                  lo_a;
        int                  hi_a;
        int                  pos;
        int                  prev_nz;
        int                  pick;
        logic [63:0]         total;
        logic [63:0]         run;
        logic [63:0]         prev_run;
        logic [79:0]         reach_l;
        logic [79:0]         reach_r;
        logic [79:0]         near_l;
        logic [79:0]         near_r;
        bit                  done;

        ans.status = STATUS_ERR;
        ans.bin    = '0;
        flip = signed_mode ? HALF_ADDR : '0;
        lo_a = int'(low_code ^ flip);
        hi_a = int'(high_code ^ flip);
        if (pct > PCT_FULL || hi_a < lo_a)
            return ans;

        total = '0;
        for (int k = lo_a; k <= hi_a; k++)
            total += 64'(bin_counts[k]);
        if (total == 0)
            return ans;

        // Skip leading empty bins; the scan starts at the first populated one.
        pos = lo_a;
        while (bin_counts[pos] == 0 && pos < hi_a)
            pos++;
        prev_nz  = pos;
        prev_run = 64'(bin_counts[pos]);
        run      = '0;
        done     = 1'b0;

        while (!done) begin
            run += 64'(bin_counts[pos]);
            reach_l = 80'(run) * 80'(PCT_FULL);
            reach_r = 80'(total) * 80'(pct);
            if (!(reach_l < reach_r) || pos >= hi_a) begin
                // Take the previous populated bin when it lies strictly nearer.
                pick   = pos;
                near_l = 80'(total) * 80'({pct, 1'b0});
                near_r = 80'(run + prev_run) * 80'(PCT_FULL);
                if (near_l < near_r && bin_counts[prev_nz] != 0)
                    pick = prev_nz;
                ans.status = STATUS_OK;
                ans.bin    = BIN_BITS'(pick) ^ flip;
                done       = 1'b1;
            end
            else begin
                if (bin_counts[pos] != 0) begin
                    prev_nz  = pos;
                    prev_run = run;
                end
                pos++;
            end
        end
        return ans;
    endfunction

    // Track both channels: results are compared in order, inputs update the shadow
    // histogram or queue the expected answer of a query.
    always @(posedge clk or negedge rst_n) begin : track
        answer_t             got;
        answer_t             want;
        logic [BIN_BITS-1:0] w_addr;

        if (!rst_n) begin
            for (int k = 0; k < NBINS; k++)
                bin_counts[k] = '0;
            signed_mode = 1'b0;
            answers_due.delete();
            failures = 0;
            mismatch_count <= 0;
            open_results   <= 0;
        end
        else begin
            if (cfg_we)
                signed_mode = cfg_wdata;

            // Result transaction against the oldest pending answer.
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser[0];
                got.bin    = m_axis_tdata[BIN_BITS-1:0];
                if (answers_due.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t: result with none pending: status %0d result_bin %0d",
                                 $time, got.status, got.bin);
                end
                else begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status || got.bin !== want.bin) begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display("%0t: mismatch: status exp %0d got %0d, result_bin exp %0d got %0d",
                                     $time, want.status, got.status, want.bin, got.bin);
                    end
                end
            end

            // Input transaction.
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == ACT_WRITE) begin
                    w_addr = s_axis_tdata[IDX_LSB +: BIN_BITS] ^ (signed_mode ? HALF_ADDR : '0);
                    bin_counts[w_addr] = s_axis_tdata[CNT_LSB +: COUNT_BITS];
                end
                else begin
                    answers_due.push_back(find_percentile(s_axis_tdata[PCT_LSB +: PCT_BITS],
                                                          s_axis_tdata[LO_LSB +: BIN_BITS],
                                                          s_axis_tdata[HI_LSB +: BIN_BITS]));
                end
            end

            mismatch_count <= failures;
            open_results   <= answers_due.size();
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import hpf_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 600;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int PHASES        = 6;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [PCT_BITS-1:0]   PCT_MAX   = '1;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_we        = 1'b0;
    logic                      cfg_wdata     = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // [7:0] bin_index, [38:8] bin_count, [61:39] percent, [69:62] low_bin,
    // [77:70] high_bin, [79:78] zero
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    // [0] action
    logic [0:0]                s_axis_tuser  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // [7:0] result_bin
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    // [0] status
    logic [0:0]                m_axis_tuser;

    int mismatch_count;
    int open_results;
    int quiet_cycles = 0;
    int rx_wait      = 0;
    bit tx_quick     = 1'b0;
    bit rx_quick     = 1'b0;
    bit mode         = 1'b0;

    always #4 clk = ~clk;

    histogram_percentile_finder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    hpf_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .open_results   (open_results)
    );

    // Idle cycles before a transaction; zero throughout a quick stretch.
    function automatic int draw_wait(input bit quick);
        if (quick)
            return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(1, 3);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    // Map a memory address to the bin code of the current mode.
    function automatic logic [BIN_BITS-1:0] addr_code(input int addr);
        return BIN_BITS'(addr) ^ (mode ? HALF_ADDR : '0);
    endfunction

    // Mostly empty and small counts, so that percentiles land on varied bins.
    function automatic logic [COUNT_BITS-1:0] draw_count();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7:           return '0;
            8, 9, 10, 11, 12, 13, 14, 15:     return COUNT_BITS'($urandom_range(1, 20));
            16, 17, 18:                       return COUNT_BITS'($urandom_range(1, 1000));
            default:                          return COUNT_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [PCT_BITS-1:0] draw_percent();
        case ($urandom_range(0, 9))
            6:       return '0;
            7:       return PCT_FULL;
            8:       return PCT_FULL - PCT_BITS'(3) + PCT_BITS'($urandom_range(0, 6));
            9:       return PCT_BITS'($urandom);
            default: return PCT_BITS'($urandom_range(0, int'(PCT_FULL)));
        endcase
    endfunction

    // Receiver: after each result transaction, hold tready low for a drawn stall.
    always @(posedge clk or negedge rst_n) begin : receiver
        int stall;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready) begin
            stall = draw_wait(rx_quick);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                rx_wait       <= stall - 1;
            end
        end
        else if (!m_axis_tready) begin
            if (rx_wait == 0)
                m_axis_tready <= 1'b1;
            else
                rx_wait <= rx_wait - 1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Drive one input transaction after a drawn gap; returns at the accepting edge.
    task automatic send_item(
        input logic                  act,
        input logic [BIN_BITS-1:0]   idx,
        input logic [COUNT_BITS-1:0] count,
        input logic [PCT_BITS-1:0]   pct,
        input logic [BIN_BITS-1:0]   lo,
        input logic [BIN_BITS-1:0]   hi
    );
        int gap;
        gap = draw_wait(tx_quick);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {2'b00, hi, lo, pct, count, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Write transactions carry random query fields, queries random write fields.
    task automatic write_bin(input logic [BIN_BITS-1:0] code, input logic [COUNT_BITS-1:0] count);
        send_item(ACT_WRITE, code, count, PCT_BITS'($urandom), BIN_BITS'($urandom),
                  BIN_BITS'($urandom));
    endtask

    task automatic query(
        input logic [PCT_BITS-1:0] pct,
        input logic [BIN_BITS-1:0] lo,
        input logic [BIN_BITS-1:0] hi
    );
        send_item(ACT_QUERY, BIN_BITS'($urandom), COUNT_BITS'($urandom), pct, lo, hi);
    endtask

    // Stop sending and wait until every pending result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input bit signed_bins);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= signed_bins;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode = signed_bins;
    endtask

    // One burst: a few writes around a focus bin, then a query, sometimes noise.
    task automatic random_burst(inout int sent);
        int focus;
        int nwrites;
        int lo_a;
        int hi_a;
        int tmp;
        focus = $urandom_range(0, NBINS - 1);
        if ($urandom_range(0, 9) == 0) begin
            send_item(logic'($urandom_range(0, 1)), BIN_BITS'($urandom), COUNT_BITS'($urandom),
                      PCT_BITS'($urandom), BIN_BITS'($urandom), BIN_BITS'($urandom));
            sent++;
        end
        else begin
            nwrites = $urandom_range(0, 6);
            repeat (nwrites)
                write_bin(addr_code((focus + $urandom_range(0, 31)) % NBINS), draw_count());
            sent += nwrites;
            case ($urandom_range(0, 9))
                0: begin
                    lo_a = 0;
                    hi_a = NBINS - 1;
                end
                7, 8, 9: begin
                    lo_a = $urandom_range(0, NBINS - 1);
                    hi_a = $urandom_range(0, NBINS - 1);
                end
                default: begin
                    lo_a = focus - $urandom_range(0, 8);
                    if (lo_a < 0)
                        lo_a = 0;
                    hi_a = focus + $urandom_range(0, 40);
                    if (hi_a > NBINS - 1)
                        hi_a = NBINS - 1;
                    if ($urandom_range(0, 19) == 0) begin
                        tmp  = lo_a;
                        lo_a = hi_a;
                        hi_a = tmp;
                    end
                end
            endcase
            query(draw_percent(), addr_code(lo_a), addr_code(hi_a));
            sent++;
        end
    endtask

    initial begin
        int sent;
        bit paused;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks in unsigned mode: empty memory, extremes and error cases.
        query(PCT_FULL >> 1, 8'd0, 8'd255);
        write_bin(8'd0, COUNT_MAX);
        write_bin(8'd255, 31'd1);
        write_bin(8'd10, 31'd5);
        write_bin(8'd20, 31'd5);
        write_bin(8'd127, COUNT_MAX);
        write_bin(8'd128, COUNT_MAX);
        query('0, 8'd0, 8'd255);
        query(PCT_FULL, 8'd0, 8'd255);
        query(PCT_FULL + 23'd1, 8'd0, 8'd255);
        query(PCT_MAX, 8'd0, 8'd255);
        query(PCT_FULL >> 1, 8'd21, 8'd20);
        query(PCT_FULL >> 1, 8'd30, 8'd100);
        query(PCT_FULL >> 1, 8'd10, 8'd20);
        query(PCT_FULL / 3, 8'd0, 8'd255);
        query(PCT_FULL >> 2, 8'd10, 8'd10);
        query(23'h55aaaa, 8'd1, 8'd254);

        // Directed checks in signed mode: signed order of ranges and of the scan.
        set_mode(1'b1);
        write_bin(8'h80, 31'd3);
        write_bin(8'h7f, 31'd4);
        write_bin(8'hff, 31'd2);
        write_bin(8'h01, COUNT_MAX);
        query(PCT_FULL >> 1, 8'h80, 8'h7f);
        query(PCT_FULL >> 1, 8'h01, 8'hff);
        query('0, 8'h80, 8'hff);
        query(PCT_FULL, 8'hff, 8'h01);

        // Random phases, alternating the mode; one phase each with a fast sender and
        // a fast receiver, and one pause for a full drain in the middle of a phase.
        sent   = 0;
        paused = 1'b0;
        for (int p = 0; p < PHASES; p++) begin
            set_mode(p % 2 == 1);
            rx_quick = (p == 2);
            while (sent < (p + 1) * RANDOM_ITEMS / PHASES) begin
                tx_quick = (p == 3) || ($urandom_range(0, 9) == 0);
                random_burst(sent);
                if (p == 1 && !paused && sent >= (3 * RANDOM_ITEMS) / (2 * PHASES)) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        // Let all results come back and watch for stray ones.
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && open_results == 0)
            $display("TEST PASSED");
        else begin
            if (open_results != 0)
                $display("%0d expected results never arrived", open_results);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
